FILE: sv/assert_macros.svh
// Assertion helpers for the hash probe block.
// Each macro takes a label, the checked expression(s) and a message string.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Expression holds at every clock edge out of reset.
`define OAHPS_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define OAHPS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define OAHPS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define OAHPS_ASSERT(lbl, expr, msg)
`define OAHPS_ASSERT_IMP(lbl, ante, cons, msg)
`define OAHPS_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

FILE: sv/oahps_pkg.sv
`timescale 1ns / 1ps

package oahps_pkg;

	localparam int TableDepth = 8192;
	localparam int KeyBits    = 31;
	localparam int AddrBits   = $clog2(TableDepth);
	localparam int SizeBits   = 14;
	localparam int CountBits  = 14;
	localparam int DivBits    = $clog2(KeyBits);

	localparam logic [SizeBits-1:0] SizeMin   = SizeBits'(3);
	localparam logic [SizeBits-1:0] SizeMax   = SizeBits'(TableDepth);
	localparam logic [SizeBits-1:0] SizeReset = SizeBits'(8192);

	localparam logic FuncWrite  = 1'b0;
	localparam logic FuncSearch = 1'b1;

	localparam logic ModeLinear = 1'b0;
	localparam logic ModeDouble = 1'b1;

	localparam logic RegTableSize = 1'b0;
	localparam logic RegProbeMode = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_READ,
		ST_CMP
	} state_t;

endpackage

FILE: sv/open_address_hash_probe_search.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Open-addressed hash table with linear or double-hash probe search.
//
// Input channel: an item is taken at a rising edge with start high and busy
// low. func selects a write (store key at slot_index, no result) or a search
// for key. Each search yields one result: probe_count and found, shown for
// one cycle with done high. The receiver cannot stall; the result is there
// for that single cycle only.
// Configuration: APB port, table_size at 0x0, probe_mode at 0x4. Write only
// while the block is idle.
// Operation: a write is stored while idle and the block stays idle. A
// search first forms the home slot and stride remainders (one key bit per
// cycle through a shared restoring divider that forms key mod size and key
// mod (size-2) together), then reads and compares each probe through the
// key store's registered read port. busy stays high while a search runs, so
// no new item is taken before it ends; busy falls together with done, so
// the next item may be accepted in that same cycle.
// Reset: the key store is swept to zero, one slot a cycle over all 8192
// slots, with busy held high; configuration writes are taken during the sweep.
module open_address_hash_probe_search
	import oahps_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// item channel
	input  logic                 start,
	output logic                 busy,
	input  logic                 func,
	input  logic [12:0]          slot_index,
	input  logic [KeyBits-1:0]   key,
	// result channel
	output logic                 done,
	output logic [CountBits-1:0] probe_count,
	output logic                 found,
	// configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	// configuration registers
	logic [SizeBits-1:0] cfg_size_q;
	logic                cfg_mode_q;
	logic                cfg_wr;
	logic [SizeBits-1:0] size_eff;

	// control
	state_t              state_q, state_d;
	logic                accept;
	logic [AddrBits-1:0] clr_addr_q;
	logic                clr_last;
	logic [DivBits-1:0]  div_cnt_q;

	// search datapath
	logic [SizeBits-1:0] size_q;
	logic                mode_q;
	logic [KeyBits-1:0]  key_q;
	logic [KeyBits-1:0]  key_sh_q;
	logic [SizeBits-1:0] rem_a_q, rem_b_q;
	logic [SizeBits-1:0] size_b;
	logic [SizeBits:0]   trial_a, trial_b;
	logic [AddrBits-1:0] loc_q;
	logic [SizeBits-1:0] step_q;
	logic [CountBits-1:0] probes_q;
	logic [SizeBits:0]   loc_sum;
	logic [AddrBits-1:0] loc_next;
	logic                hit;
	logic                last_probe;

	// key store
	logic [KeyBits-1:0]  mem [TableDepth];
	logic [KeyBits-1:0]  rd_data_q;
	logic                mem_we;
	logic [AddrBits-1:0] mem_wa;
	logic [KeyBits-1:0]  mem_wd;

	// result registers
	logic                done_q;
	logic [CountBits-1:0] count_q;
	logic                found_q;

	// ---------------------------------------------------------------
	// Configuration port
	// ---------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_size_q <= SizeReset;
			cfg_mode_q <= ModeLinear;
		end else if (cfg_wr) begin
			case (paddr[2])
				RegTableSize: cfg_size_q <= pwdata[SizeBits-1:0];
				RegProbeMode: cfg_mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			RegTableSize: prdata = {{(32-SizeBits){1'b0}}, cfg_size_q};
			RegProbeMode: prdata = {31'b0, cfg_mode_q};
			default:      prdata = '0;
		endcase
	end

	// clamp the programmed size to the usable range
	always_comb begin
		if (cfg_size_q < SizeMin) begin
			size_eff = SizeMin;
		end else if (cfg_size_q > SizeMax) begin
			size_eff = SizeMax;
		end else begin
			size_eff = cfg_size_q;
		end
	end

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	assign accept     = start & ~busy;
	assign clr_last   = (clr_addr_q == AddrBits'(TableDepth - 1));
	assign hit        = (rd_data_q == key_q);
	assign last_probe = (probes_q == size_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_last) state_d = ST_IDLE;
			ST_IDLE:  if (accept && func == FuncSearch) state_d = ST_DIV;
			ST_DIV:   if (div_cnt_q == '0) state_d = ST_READ;
			ST_READ:  state_d = ST_CMP;
			ST_CMP:   state_d = (hit || last_probe) ? ST_IDLE : ST_READ;
			default:  state_d = ST_IDLE;
		endcase
	end

	// busy, and the store's write port: sweep during clear, item writes when idle
	always_comb begin
		busy   = 1'b1;
		mem_we = 1'b0;
		mem_wa = clr_addr_q;
		mem_wd = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				busy   = 1'b0;
				mem_we = accept && (func == FuncWrite);
				mem_wa = slot_index;
				mem_wd = key;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			done_q <= (state_q == ST_CMP) && (hit || last_probe);
		end
	end

	// ---------------------------------------------------------------
	// Remainder unit: key mod size and key mod (size-2), one bit a cycle
	// ---------------------------------------------------------------
	assign size_b  = size_q - SizeBits'(2);
	assign trial_a = {rem_a_q, key_sh_q[KeyBits-1]};
	assign trial_b = {rem_b_q, key_sh_q[KeyBits-1]};

	// next probe slot: loc + step stays below twice the size
	assign loc_sum  = {2'b0, loc_q} + {1'b0, step_q};
	assign loc_next = (loc_sum >= {1'b0, size_q}) ?
		AddrBits'(loc_sum - {1'b0, size_q}) : AddrBits'(loc_sum);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				// latch the item and the clamped configuration
				size_q    <= size_eff;
				mode_q    <= cfg_mode_q;
				key_q     <= key;
				key_sh_q  <= key;
				rem_a_q   <= '0;
				rem_b_q   <= '0;
				div_cnt_q <= DivBits'(KeyBits - 1);
			end
			ST_DIV: begin
				key_sh_q  <= key_sh_q << 1;
				div_cnt_q <= div_cnt_q - 1'b1;
				rem_a_q   <= (trial_a >= {1'b0, size_q}) ?
					SizeBits'(trial_a - {1'b0, size_q}) : SizeBits'(trial_a);
				rem_b_q   <= (trial_b >= {1'b0, size_b}) ?
					SizeBits'(trial_b - {1'b0, size_b}) : SizeBits'(trial_b);
				if (div_cnt_q == '0) begin
					// final remainder bit is folded in here
					loc_q    <= (trial_a >= {1'b0, size_q}) ?
						AddrBits'(trial_a - {1'b0, size_q}) : AddrBits'(trial_a);
					step_q   <= (mode_q == ModeDouble) ?
						((trial_b >= {1'b0, size_b}) ?
							SizeBits'(trial_b - {1'b0, size_b}) + 1'b1 :
							SizeBits'(trial_b) + 1'b1) :
						SizeBits'(1);
					probes_q <= CountBits'(1);
				end
			end
			ST_CMP: begin
				// advance to the next slot on a miss
				loc_q    <= loc_next;
				probes_q <= probes_q + 1'b1;
				count_q  <= probes_q;
				found_q  <= hit;
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------
	// Key store: one write port, one registered read port
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_q <= mem[loc_q];
	end

	assign done        = done_q;
	assign probe_count = count_q;
	assign found       = found_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`OAHPS_ASSERT_IMP(a_done_idle, done_q, state_q == ST_IDLE, "result while busy")
	`OAHPS_ASSERT_IMP(a_loc_range, state_q == ST_READ || state_q == ST_CMP,
		{1'b0, loc_q} < size_q, "probe slot outside table")
	`OAHPS_ASSERT_IMP(a_step_range, state_q == ST_READ,
		step_q != '0 && step_q < size_q, "probe stride out of range")
	`OAHPS_ASSERT_IMP(a_count_range, done_q,
		probe_count != '0 && probe_count <= size_q, "probe count out of range")
	`OAHPS_ASSERT_IMP(a_miss_full, done_q && !found_q, probe_count == size_q,
		"miss before all probes used")
	`OAHPS_ASSERT_NXT(a_search_starts, accept && func == FuncSearch,
		state_q == ST_DIV, "search not started")

endmodule

FILE: tb/open_address_hash_probe_search_test.sv
`timescale 1ns / 1ps

module open_address_hash_probe_search_test;
	import oahps_pkg::*;

	// a full-table miss is a long search; leave room for such misses
	localparam int CycleLimit = 40000000;
	localparam int WideSize   = 128;   // above this, steer searches away from long misses
	localparam int PoolDepth  = 32;

	typedef struct packed {
		logic [CountBits-1:0] count;
		logic                 hit;
	} search_result_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_REG
	} row_kind_t;

	typedef struct {
		row_kind_t            kind;
		logic                 op;
		logic [12:0]          slot;
		logic [KeyBits-1:0]   k;
		logic                 reg_index;
		logic [31:0]          value;
		bit                   typed;
		logic [CountBits-1:0] count;
		logic                 hit;
	} stim_row_t;

	typedef struct {
		int   size;
		logic mode;
		int   idle_pct;
		int   items;
	} phase_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic                 func;
	logic [12:0]          slot_index;
	logic [KeyBits-1:0]   key;
	logic                 done;
	logic [CountBits-1:0] probe_count;
	logic                 found;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [2:0]           paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;

	// Shadow of the block: key store and both registers.
	logic [KeyBits-1:0]  key_store [TableDepth];
	logic [SizeBits-1:0] size_reg;
	logic                mode_reg;

	search_result_t     expected_results [$];
	logic [KeyBits-1:0] written_keys [$];
	int                 mismatch_count;
	int                 cycle_count;

	// Directed rows. Expected values are typed in only where they follow
	// directly from the reset state or an extreme; the rest go through the
	// predictor.
	stim_row_t directed_rows [27] = '{
		// empty store, reset size: key zero sits in its home slot
		'{ROW_ITEM, FuncSearch, 13'd0, 31'd0, RegTableSize, 32'd0, 1'b1, 14'd1, 1'b1},
		// largest key misses everywhere: full table of probes, count at its widest
		'{ROW_ITEM, FuncSearch, 13'd0, 31'h7FFFFFFF, RegTableSize, 32'd0, 1'b1, 14'd8192, 1'b0},
		'{ROW_ITEM, FuncWrite, 13'd8191, 31'h7FFFFFFF, RegTableSize, 32'd0, 1'b0, 14'd0, 1'b0},
		'{ROW_ITEM, FuncSearch, 13'd0, 31'h7FFFFFFF, RegTableSize, 32'd0, 1'b1, 14'd1, 1'b1},
		// fill slots 0 and 1 so key zero has to walk to slot 2
		'{ROW_ITEM, FuncWrite, 13'd0, 31'd8192, RegTableSize, 32'd0, 1'b0, 14'd0, 1'b0},
		'{ROW_ITEM, FuncWrite, 13'd1, 31'd1, RegTableSize, 32'd0, 1'b0, 14'd0, 1'b0},
		'{ROW_ITEM, FuncSearch, 13'd0, 31'd0, RegTableSize, 32'd0, 1'b1, 14'd3, 1'b1},
		// size below the floor: treated as three
		'{ROW_REG, FuncWrite, 13'd0, 31'd0, RegTableSize, 32'd2, 1'b0, 14'd0, 1'b0},
		'{ROW_ITEM, FuncSearch, 13'd0, 31'd5, RegTableSize, 32'd0, 1'b0, 14'd0, 1'b0},
		// slot past the active size is kept but never probed
		'{ROW_ITEM, FuncWrite, 13'd5, 31'd77, RegTableSize, 32'd0, 1'b0, 14'd0, 1'b0},
		'{ROW_ITEM, FuncSearch, 13'd0, 31'd77, RegTableSize, 32'd0, 1'b0, 14'd0, 1'b0},
		'{ROW_REG, FuncWrite, 13'd0, 31'd0, RegProbeMode, 32'(ModeDouble), 1'b0, 14'd0, 1'b0},
		'{ROW_REG, FuncWrite, 13'd0, 31'd0, RegTableSize, 32'd5, 1'b0, 14'd0, 1'b0},
		'{ROW_ITEM, FuncWrite, 13'd2, 31'd7, RegTableSize, 32'd0, 1'b0, 14'd0, 1'b0},
		'{ROW_ITEM, FuncSearch, 13'd0, 31'd7, RegTableSize, 32'd0, 1'b0, 14'd0, 1'b0},
		'{ROW_ITEM, FuncSearch, 13'd0, 31'd12, RegTableSize, 32'd0, 1'b0, 14'd0, 1'b0},
		// size six, key two: stride three bounces between slots 2 and 5
		'{ROW_REG, FuncWrite, 13'd0, 31'd0, RegTableSize, 32'd6, 1'b0, 14'd0, 1'b0},
		'{ROW_ITEM, FuncSearch, 13'd0, 31'd2, RegTableSize, 32'd0, 1'b0, 14'd0, 1'b0},
		// size above the store: treated as the store depth
		'{ROW_REG, FuncWrite, 13'd0, 31'd0, RegTableSize, 32'd16383, 1'b0, 14'd0, 1'b0},
		'{ROW_ITEM, FuncSearch, 13'd0, 31'h7FFFFFFF, RegTableSize, 32'd0, 1'b1, 14'd1, 1'b1},
		'{ROW_REG, FuncWrite, 13'd0, 31'd0, RegTableSize, 32'd0, 1'b0, 14'd0, 1'b0},
		'{ROW_ITEM, FuncSearch, 13'd0, 31'd0, RegTableSize, 32'd0, 1'b0, 14'd0, 1'b0},
		'{ROW_ITEM, FuncWrite, 13'h1555, 31'h2AAAAAAA, RegTableSize, 32'd0, 1'b0, 14'd0, 1'b0},
		'{ROW_ITEM, FuncSearch, 13'd0, 31'h2AAAAAAA, RegTableSize, 32'd0, 1'b0, 14'd0, 1'b0},
		// back to full size, linear: the far slot becomes reachable
		'{ROW_REG, FuncWrite, 13'd0, 31'd0, RegProbeMode, 32'(ModeLinear), 1'b0, 14'd0, 1'b0},
		'{ROW_REG, FuncWrite, 13'd0, 31'd0, RegTableSize, 32'd8192, 1'b0, 14'd0, 1'b0},
		'{ROW_ITEM, FuncSearch, 13'd0, 31'h2AAAAAAA, RegTableSize, 32'd0, 1'b0, 14'd0, 1'b0}
	};

	// Random phases: size, mode, percent of sender idle, item count.
	phase_t phases [12] = '{
		'{3, ModeLinear, 0, 60},
		'{4, ModeDouble, 59, 60},
		'{7, ModeLinear, 36, 60},
		'{13, ModeDouble, 0, 60},
		'{31, ModeLinear, 59, 60},
		'{64, ModeDouble, 36, 60},
		'{97, ModeLinear, 0, 60},
		'{16383, ModeDouble, 59, 15},
		'{5, ModeDouble, 36, 60},
		'{0, ModeDouble, 0, 40},
		'{100, ModeDouble, 59, 60},
		'{8192, ModeLinear, 0, 15}
	};

	open_address_hash_probe_search i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.slot_index  (slot_index),
		.key         (key),
		.done        (done),
		.probe_count (probe_count),
		.found       (found),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Clamp the size register the way the block does.
	function automatic int clamped_size();
		int s;
		s = int'(size_reg);
		if (s < int'(SizeMin))
			s = int'(SizeMin);
		if (s > TableDepth)
			s = TableDepth;
		return s;
	endfunction

	// Walk the probe sequence over the shadow store; give up after one
	// full table of probes.
	function automatic search_result_t predict_search(input logic [KeyBits-1:0] k);
		search_result_t r;
		int             eff;
		int             loc;
		int             stride;
		eff    = clamped_size();
		loc    = int'(k % eff);
		stride = (mode_reg == ModeDouble) ? int'(k % (eff - 2)) + 1 : 1;
		r.count = CountBits'(eff);
		r.hit   = 1'b0;
		for (int n = 1; n <= eff; n++) begin
			if (key_store[loc] == k) begin
				r.count = CountBits'(n);
				r.hit   = 1'b1;
				break;
			end
			loc = (loc + stride) % eff;
		end
		return r;
	endfunction

	// Present one item from the falling edge on and hold it until accepted.
	// start stays high afterwards; the caller drops it when idling.
	task automatic send_item(input logic op, input logic [12:0] slot,
			input logic [KeyBits-1:0] k, input bit typed,
			input logic [CountBits-1:0] tcount, input logic thit);
		search_result_t r;
		@(negedge clk);
		start      = 1'b1;
		func       = op;
		slot_index = slot;
		key        = k;
		do
			@(posedge clk);
		while (busy);
		if (op == FuncSearch) begin
			if (typed) begin
				r.count = tcount;
				r.hit   = thit;
			end else begin
				r = predict_search(k);
			end
			expected_results.push_back(r);
		end else begin
			key_store[slot] = k;
			written_keys.push_back(k);
			if (written_keys.size() > PoolDepth)
				void'(written_keys.pop_front());
		end
	endtask

	// Drop start, let every pending search come back, then wait out any
	// write still in flight before touching the registers.
	task automatic wait_until_quiet();
		@(negedge clk);
		start = 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Setup and access cycle; the register lands when pready is seen high.
	task automatic write_register(input logic idx, input logic [31:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (idx == RegTableSize)
			size_reg = value[SizeBits-1:0];
		else
			mode_reg = value[0];
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// Build a well-formed sequence: writes cluster around each key's home
	// slot so probes collide, and most searches ask for keys just written.
	// In wide tables keep searches on written keys or zero to avoid full misses.
	task automatic random_item(input bit wide);
		logic [KeyBits-1:0] k;
		logic [12:0]        slot;
		int                 eff;
		int                 pick;
		eff  = clamped_size();
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			if (!wide && written_keys.size() != 0 && $urandom_range(0, 4) == 0)
				k = written_keys[$urandom_range(0, written_keys.size() - 1)];
			else
				k = KeyBits'($urandom());
			if (wide)
				slot = 13'(k % eff);
			else if ($urandom_range(0, 3) == 0)
				slot = 13'($urandom());
			else
				slot = 13'((k % eff + $urandom_range(0, 3)) % eff);
			send_item(FuncWrite, slot, k, 1'b0, '0, 1'b0);
		end else begin
			// slot is don't-care for a search; toggle it anyway
			slot = 13'($urandom());
			pick = $urandom_range(0, 99);
			if (written_keys.size() != 0 && pick < (wide ? 85 : 55))
				k = written_keys[$urandom_range(0, written_keys.size() - 1)];
			else if (wide || pick < 70)
				k = '0;
			else
				k = KeyBits'($urandom());
			send_item(FuncSearch, slot, k, 1'b0, '0, 1'b0);
		end
	endtask

	// Results cannot be stalled: check every done pulse against the oldest
	// pending search.
	always @(posedge clk) begin
		search_result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t unexpected result: probe_count %0d found %0b",
					$time, probe_count, found);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				if (probe_count !== want.count) begin
					$display("%0t probe_count mismatch: expected %0d, actual %0d",
						$time, want.count, probe_count);
					mismatch_count++;
				end
				if (found !== want.hit) begin
					$display("%0t found mismatch: expected %0b, actual %0b",
						$time, want.hit, found);
					mismatch_count++;
				end
			end
		end
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		bit wide;
		mismatch_count = 0;
		cycle_count    = 0;
		arst_n     = 1'b0;
		start      = 1'b0;
		func       = FuncWrite;
		slot_index = '0;
		key        = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		foreach (key_store[i])
			key_store[i] = '0;
		size_reg = SizeReset;
		mode_reg = ModeLinear;

		// Hold reset, then release on a falling edge. The store sweep that
		// follows keeps busy high, so the first item simply waits.
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed rows: items back to back, register rows once the block is quiet.
		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_REG) begin
				wait_until_quiet();
				write_register(directed_rows[r].reg_index, directed_rows[r].value);
			end else begin
				send_item(directed_rows[r].op, directed_rows[r].slot,
					directed_rows[r].k, directed_rows[r].typed,
					directed_rows[r].count, directed_rows[r].hit);
			end
		end

		// Random phases: reconfigure while idle, then stream items with the
		// phase's share of sender gaps. Gaps have a random length so they
		// land on every stage of a search.
		foreach (phases[p]) begin
			wait_until_quiet();
			write_register(RegTableSize, 32'(phases[p].size));
			write_register(RegProbeMode, 32'(phases[p].mode));
			written_keys.delete();
			wide = clamped_size() > WideSize;
			for (int i = 0; i < phases[p].items; i++) begin
				while ($urandom_range(0, 99) < phases[p].idle_pct) begin
					@(negedge clk);
					start = 1'b0;
					repeat ($urandom_range(1, 40)) @(negedge clk);
				end
				random_item(wide);
			end
		end

		// Drain, then give a trailing write time to settle.
		@(negedge clk);
		start = 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
